@@ hw/rtl/pscr_pkg.sv @@
`timescale 1ns / 1ps

package pscr_pkg;

  localparam int ID_W     = 10;
  localparam int SLOT_W   = 4;
  localparam int DUR_W    = 32;
  localparam int SR_W     = 20;
  localparam int ACT_W    = 5;
  localparam int TOT_W    = 48;
  localparam int RATE_W   = 40;
  localparam int FRAC_W   = 8;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_SPIKE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CELLS  = 1'd1;

  localparam logic [SR_W-1:0]  SR_RESET  = 20'd20000;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

endpackage

@@ hw/rtl/pscr_ram.sv @@
`timescale 1ns / 1ps

module pscr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/pscr_rate_div.sv @@
`timescale 1ns / 1ps

// shift-add multiply count*sr, then restoring divide of (product << 8) by den
module pscr_rate_div #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [COUNT_WIDTH-1:0]        count,
  input  logic [pscr_pkg::SR_W-1:0]     sr,
  input  logic [pscr_pkg::TOT_W-1:0]    den,
  output logic                          done,
  output logic [pscr_pkg::RATE_W-1:0]   rate
);

  localparam int PW     = COUNT_WIDTH + pscr_pkg::SR_W;
  localparam int NW     = PW + pscr_pkg::FRAC_W;
  localparam int STEP_W = $clog2(NW + 1);
  localparam int TW     = pscr_pkg::TOT_W;
  localparam int RW     = pscr_pkg::RATE_W;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  logic [1:0]                ust_r, ust_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [PW-1:0]             acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0]    mc_r, mc_nxt;
  logic [pscr_pkg::SR_W-1:0] mlt_r, mlt_nxt;
  logic [TW-1:0]             den_r, den_nxt;
  logic [TW-1:0]             rem_r, rem_nxt;
  logic [NW-1:0]             num_r, num_nxt;
  logic [NW-1:0]             q_r, q_nxt;
  logic                      done_r, done_nxt;

  logic [PW-1:0]   mul_sum;
  logic [TW:0]     sh;
  logic [TW:0]     diff;
  logic [NW+RW-1:0] q_ext;

  assign mul_sum = {acc_r[PW-2:0], 1'b0} + (mlt_r[pscr_pkg::SR_W-1] ? PW'(mc_r) : '0);
  assign sh      = {rem_r, num_r[NW-1]};
  assign diff    = sh - {1'b0, den_r};

  always_comb begin
    ust_nxt  = ust_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mlt_nxt  = mlt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    case (ust_r)
      U_IDLE: begin
        if (start) begin
          mc_nxt   = count;
          mlt_nxt  = sr;
          den_nxt  = den;
          acc_nxt  = '0;
          step_nxt = '0;
          ust_nxt  = U_MUL;
        end
      end
      U_MUL: begin
        acc_nxt  = mul_sum;
        mlt_nxt  = {mlt_r[pscr_pkg::SR_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(pscr_pkg::SR_W - 1)) begin
          num_nxt  = {mul_sum, {pscr_pkg::FRAC_W{1'b0}}};
          rem_nxt  = '0;
          q_nxt    = '0;
          step_nxt = '0;
          ust_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        num_nxt  = {num_r[NW-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (!diff[TW]) begin
          rem_nxt = diff[TW-1:0];
          q_nxt   = {q_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = sh[TW-1:0];
          q_nxt   = {q_r[NW-2:0], 1'b0};
        end
        if (step_r == STEP_W'(NW - 1)) begin
          done_nxt = 1'b1;
          ust_nxt  = U_IDLE;
        end
      end
      default: ust_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    mlt_r  <= mlt_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    q_r    <= q_nxt;
  end

  assign q_ext = {{RW{1'b0}}, q_r};
  assign done  = done_r;
  assign rate  = (|q_ext[NW+RW-1:RW]) ? pscr_pkg::RATE_MAX : q_ext[RW-1:0];

endmodule

@@ hw/rtl/per_cell_spike_rate_counter.sv @@
`timescale 1ns / 1ps

// Load and close: handled in IDLE. Spike: steps through the active_limit active slots,
//   one slot per cycle through the cell table and count RAM read ports.
// Report: per slot, a table/count read, then the serial multiply/divide unit (skipped when
//   total time is zero), plus output stall; one transaction at a time.
// Reset (sync, rst_n low): counts and total cleared, config to defaults,
//   cell table undefined until loaded.
module per_cell_spike_rate_counter #(
  parameter int NUM_CELLS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pscr_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pscr_pkg::ID_W-1:0]         in_cluster_id,
  input  logic [pscr_pkg::SLOT_W-1:0]       in_slot,
  input  logic [pscr_pkg::DUR_W-1:0]        in_duration,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pscr_pkg::SLOT_W-1:0]       out_cell_slot,
  output logic [pscr_pkg::RATE_W-1:0]       out_rate_q8,
  output logic                              out_no_time,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [pscr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pscr_pkg::SR_W-1:0]         cfg_wdata
);

  localparam int IDX_W = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
  localparam int CNT_W = $clog2(NUM_CELLS + 1);
  localparam int TW    = pscr_pkg::TOT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SPK  = 3'd1;
  localparam logic [2:0] S_RRD  = 3'd2;
  localparam logic [2:0] S_RCAP = 3'd3;
  localparam logic [2:0] S_RDIV = 3'd4;
  localparam logic [2:0] S_ROUT = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              i_r, i_nxt;
  logic [pscr_pkg::ID_W-1:0]     id_r, id_nxt;
  logic                          pend_r, pend_nxt;
  logic [IDX_W-1:0]              widx_r, widx_nxt;
  logic                          vld_q_r, vld_q_nxt;
  logic [TW-1:0]                 total_r, total_nxt;
  logic [pscr_pkg::SR_W-1:0]     sr_r, sr_nxt;
  logic [pscr_pkg::ACT_W-1:0]    act_r, act_nxt;
  logic [NUM_CELLS-1:0]          cnt_vld_r, cnt_vld_nxt;
  logic [pscr_pkg::RATE_W-1:0]   rate_hold_r, rate_hold_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [pscr_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [pscr_pkg::RATE_W-1:0]   out_rate_r, out_rate_nxt;
  logic                          out_nt_r, out_nt_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CNT_W-1:0]              lim;
  logic                          in_acc;
  logic                          out_free;
  logic                          total_zero;
  logic [TW:0]                   tot_sum;

  logic                          tbl_we;
  logic                          rd_en;
  logic [pscr_pkg::ID_W-1:0]     tbl_rdata;
  logic                          cnt_we;
  logic [COUNT_WIDTH-1:0]        cnt_wdata;
  logic [COUNT_WIDTH-1:0]        cnt_rdata;
  logic [COUNT_WIDTH-1:0]        cnt_cur;
  logic [IDX_W-1:0]              ridx;

  logic                          div_start;
  logic                          div_done;
  logic [pscr_pkg::RATE_W-1:0]   div_rate;

  assign lim        = (32'(act_r) > NUM_CELLS) ? CNT_W'(NUM_CELLS) : CNT_W'(act_r);
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign total_zero = (total_r == '0);
  assign tot_sum    = {1'b0, total_r} + (TW + 1)'(in_duration);
  assign ridx       = i_r[IDX_W-1:0];
  assign cnt_cur    = vld_q_r ? cnt_rdata : '0;

  assign tbl_we = in_acc && (in_cmd == pscr_pkg::CMD_LOAD) && (32'(in_slot) < NUM_CELLS);
  assign rd_en  = ((state_r == S_SPK) && (i_r < lim)) || (state_r == S_RRD);

  pscr_ram #(
    .WIDTH (pscr_pkg::ID_W),
    .DEPTH (NUM_CELLS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_W'(in_slot)),
    .wdata (in_cluster_id),
    .re    (rd_en),
    .raddr (ridx),
    .rdata (tbl_rdata)
  );

  pscr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_CELLS)
  ) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (widx_r),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (ridx),
    .rdata (cnt_rdata)
  );

  pscr_rate_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .count (cnt_cur),
    .sr    (sr_r),
    .den   (total_r),
    .done  (div_done),
    .rate  (div_rate)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    id_nxt        = id_r;
    pend_nxt      = 1'b0;
    widx_nxt      = widx_r;
    vld_q_nxt     = vld_q_r;
    total_nxt     = total_r;
    sr_nxt        = sr_r;
    act_nxt       = act_r;
    cnt_vld_nxt   = cnt_vld_r;
    rate_hold_nxt = rate_hold_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_rate_nxt  = out_rate_r;
    out_nt_nxt    = out_nt_r;
    out_last_nxt  = out_last_r;
    cnt_we        = 1'b0;
    cnt_wdata     = cnt_cur + 1'b1;
    div_start     = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        pscr_pkg::CFG_SAMPLING_RATE: sr_nxt  = cfg_wdata;
        pscr_pkg::CFG_ACTIVE_CELLS:  act_nxt = cfg_wdata[pscr_pkg::ACT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (rd_en) begin
      vld_q_nxt = cnt_vld_r[ridx];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            pscr_pkg::CMD_SPIKE: begin
              id_nxt    = in_cluster_id;
              i_nxt     = '0;
              state_nxt = S_SPK;
            end
            pscr_pkg::CMD_CLOSE: begin
              total_nxt = tot_sum[TW] ? pscr_pkg::TOT_MAX : tot_sum[TW-1:0];
            end
            pscr_pkg::CMD_REPORT: begin
              i_nxt = '0;
              if (lim == '0) begin
                cnt_vld_nxt = '0;
                total_nxt   = '0;
              end else begin
                state_nxt = S_RRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SPK: begin
        if (i_r < lim) begin
          pend_nxt = 1'b1;
          widx_nxt = ridx;
          i_nxt    = i_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_IDLE;
        end
        if (pend_r && (tbl_rdata == id_r) && (cnt_cur != COUNT_MAX)) begin
          cnt_we              = 1'b1;
          cnt_vld_nxt[widx_r] = 1'b1;
        end
      end
      S_RRD: begin
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        if (total_zero) begin
          rate_hold_nxt = pscr_pkg::RATE_MAX;
          state_nxt     = S_ROUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          rate_hold_nxt = div_rate;
          state_nxt     = S_ROUT;
        end
      end
      S_ROUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = pscr_pkg::SLOT_W'(i_r);
          out_rate_nxt  = rate_hold_r;
          out_nt_nxt    = total_zero;
          out_last_nxt  = (i_r + 1'b1 == lim);
          if (i_r + 1'b1 == lim) begin
            cnt_vld_nxt = '0;
            total_nxt   = '0;
            state_nxt   = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      total_r     <= '0;
      sr_r        <= pscr_pkg::SR_RESET;
      act_r       <= pscr_pkg::ACT_RESET;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      sr_r        <= sr_nxt;
      act_r       <= act_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r         <= i_nxt;
    id_r        <= id_nxt;
    widx_r      <= widx_nxt;
    vld_q_r     <= vld_q_nxt;
    rate_hold_r <= rate_hold_nxt;
    out_slot_r  <= out_slot_nxt;
    out_rate_r  <= out_rate_nxt;
    out_nt_r    <= out_nt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cell_slot = out_slot_r;
  assign out_rate_q8   = out_rate_r;
  assign out_no_time   = out_nt_r;
  assign out_last      = out_last_r;

endmodule

@@ bench/tb_per_cell_spike_rate_counter.sv @@
`timescale 1ns / 1ps

module tb_per_cell_spike_rate_counter;

  localparam int NUM_CELLS    = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE       = 100;
  localparam int RANDOM_ITEMS = 200;
  localparam int PHASES       = 6;

  typedef struct packed {
    logic [pscr_pkg::SLOT_W-1:0] cell_slot;
    logic [pscr_pkg::RATE_W-1:0] rate_q8;
    logic                        no_time;
    logic                        last;
  } rate_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [pscr_pkg::CMD_W-1:0]     in_cmd;
  logic [pscr_pkg::ID_W-1:0]      in_cluster_id;
  logic [pscr_pkg::SLOT_W-1:0]    in_slot;
  logic [pscr_pkg::DUR_W-1:0]     in_duration;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [pscr_pkg::SLOT_W-1:0]    out_cell_slot;
  logic [pscr_pkg::RATE_W-1:0]    out_rate_q8;
  logic                           out_no_time;
  logic                           out_last;
  logic                           cfg_we;
  logic [pscr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pscr_pkg::SR_W-1:0]      cfg_wdata;

  rate_result_t                   expected_rates[$];
  rate_result_t                   exp_rate;
  logic [pscr_pkg::ID_W-1:0]      cell_ids [NUM_CELLS];
  logic [COUNT_WIDTH-1:0]         spike_cnt [NUM_CELLS];
  logic [pscr_pkg::TOT_W-1:0]     total_time;
  logic [pscr_pkg::SR_W-1:0]      sr_reg;
  logic [pscr_pkg::ACT_W-1:0]     act_reg;
  int                             err_cnt    = 0;
  int                             cycle_cnt  = 0;
  int                             ready_hold = 0;
  bit                             idling_on  = 1'b1;

  per_cell_spike_rate_counter #(
    .NUM_CELLS   (NUM_CELLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_cluster_id (in_cluster_id),
    .in_slot       (in_slot),
    .in_duration   (in_duration),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_slot (out_cell_slot),
    .out_rate_q8   (out_rate_q8),
    .out_no_time   (out_no_time),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!idling_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= ($urandom_range(0, 99) < 65);
      ready_hold <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rates.size() == 0) begin
        $error("unexpected result: cell_slot %0d rate_q8 %0d", out_cell_slot, out_rate_q8);
        err_cnt++;
      end else begin
        exp_rate = expected_rates.pop_front();
        if (out_cell_slot !== exp_rate.cell_slot) begin
          $error("cell_slot: expected %0d, actual %0d", exp_rate.cell_slot, out_cell_slot);
          err_cnt++;
        end
        if (out_rate_q8 !== exp_rate.rate_q8) begin
          $error("rate_q8: expected %0d, actual %0d", exp_rate.rate_q8, out_rate_q8);
          err_cnt++;
        end
        if (out_no_time !== exp_rate.no_time) begin
          $error("no_time: expected %0d, actual %0d", exp_rate.no_time, out_no_time);
          err_cnt++;
        end
        if (out_last !== exp_rate.last) begin
          $error("last: expected %0d, actual %0d", exp_rate.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  // floor(count * rate * 256 / total), clipped to the output width
  function automatic logic [pscr_pkg::RATE_W-1:0] firing_rate_q8(
      input logic [COUNT_WIDTH-1:0] cnt,
      input logic [pscr_pkg::SR_W-1:0] sr,
      input logic [pscr_pkg::TOT_W-1:0] tot);
    logic [63:0] num;
    logic [63:0] q;
    num = (64'(cnt) * 64'(sr)) << pscr_pkg::FRAC_W;
    q   = num / 64'(tot);
    return (q > 64'(pscr_pkg::RATE_MAX)) ? pscr_pkg::RATE_MAX : q[pscr_pkg::RATE_W-1:0];
  endfunction

  task automatic update_rate_model(input logic [pscr_pkg::CMD_W-1:0] cmd,
                                   input logic [pscr_pkg::ID_W-1:0] id,
                                   input logic [pscr_pkg::SLOT_W-1:0] slot,
                                   input logic [pscr_pkg::DUR_W-1:0] dur);
    int                         n;
    logic [pscr_pkg::TOT_W:0]   sum;
    rate_result_t               r;
    n = (act_reg > NUM_CELLS) ? NUM_CELLS : int'(act_reg);
    case (cmd)
      pscr_pkg::CMD_SPIKE: begin
        for (int i = 0; i < n; i++)
          if (cell_ids[i] == id && spike_cnt[i] != '1) spike_cnt[i]++;
      end
      pscr_pkg::CMD_CLOSE: begin
        sum        = total_time + dur;
        total_time = (sum > pscr_pkg::TOT_MAX) ? pscr_pkg::TOT_MAX
                                               : sum[pscr_pkg::TOT_W-1:0];
      end
      pscr_pkg::CMD_LOAD: begin
        if (slot < NUM_CELLS) cell_ids[slot] = id;
      end
      pscr_pkg::CMD_REPORT: begin
        for (int i = 0; i < n; i++) begin
          r.cell_slot = pscr_pkg::SLOT_W'(i);
          r.no_time   = (total_time == '0);
          r.rate_q8   = r.no_time ? pscr_pkg::RATE_MAX
                                  : firing_rate_q8(spike_cnt[i], sr_reg, total_time);
          r.last      = (i == n - 1);
          expected_rates.push_back(r);
        end
        for (int i = 0; i < NUM_CELLS; i++) spike_cnt[i] = '0;
        total_time = '0;
      end
      default: ;
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic [pscr_pkg::CMD_W-1:0] cmd,
                           input logic [pscr_pkg::ID_W-1:0] id,
                           input logic [pscr_pkg::SLOT_W-1:0] slot,
                           input logic [pscr_pkg::DUR_W-1:0] dur);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_cluster_id <= id;
    in_slot       <= slot;
    in_duration   <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_rate_model(cmd, id, slot, dur);
    @(negedge clk);
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [pscr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pscr_pkg::SR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pscr_pkg::CFG_SAMPLING_RATE) sr_reg = data;
    else act_reg = data[pscr_pkg::ACT_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic [pscr_pkg::SR_W-1:0] pick_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 30) return pscr_pkg::SR_W'(1);
    if (r < 50) return pscr_pkg::SR_RESET;
    return pscr_pkg::SR_W'($urandom_range(1, 1000000));
  endfunction

  function automatic logic [pscr_pkg::SR_W-1:0] pick_active();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 20) return pscr_pkg::SR_W'($urandom_range(NUM_CELLS + 1, 31));
    if (r < 35) return pscr_pkg::SR_W'(1);
    if (r < 50) return pscr_pkg::SR_W'(NUM_CELLS);
    return pscr_pkg::SR_W'($urandom_range(1, NUM_CELLS));
  endfunction

  // every slot gets an id before any spike or report; slots 1 and 4 share one
  task automatic test_load_table();
    logic [pscr_pkg::ID_W-1:0] ids [NUM_CELLS];
    ids[0] = 10'h000;
    ids[1] = 10'h3FF;
    ids[2] = 10'h2AA;
    ids[3] = 10'h155;
    ids[4] = 10'h3FF;
    for (int k = 5; k < NUM_CELLS; k++) ids[k] = pscr_pkg::ID_W'(16 * k + 7);
    for (int k = 0; k < NUM_CELLS; k++)
      send_item(pscr_pkg::CMD_LOAD, ids[k], pscr_pkg::SLOT_W'(k), $urandom);
  endtask

  task automatic test_spike_close_report();
    send_item(pscr_pkg::CMD_SPIKE, 10'h3FF, 4'hF, $urandom);
    send_item(pscr_pkg::CMD_SPIKE, 10'h3FF, 4'h0, $urandom);
    send_item(pscr_pkg::CMD_SPIKE, 10'h000, 4'h5, $urandom);
    send_item(pscr_pkg::CMD_SPIKE, 10'h2AA, 4'hA, $urandom);
    send_item(pscr_pkg::CMD_SPIKE, 10'h300, 4'h3, $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd0);
    send_item(pscr_pkg::CMD_CLOSE, 10'h3FF, 4'hF, 32'd12345);
    send_item(pscr_pkg::CMD_REPORT, 10'h155, 4'h7, $urandom);
  endtask

  task automatic test_zero_time();
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    send_item(pscr_pkg::CMD_SPIKE, 10'h155, 4'h2, $urandom);
    send_item(pscr_pkg::CMD_REPORT, 10'h3FF, 4'hF, $urandom);
  endtask

  task automatic test_active_cells();
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, 20'd0);
    send_item(pscr_pkg::CMD_SPIKE, 10'h3FF, 4'h1, $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd500);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, 20'd1);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd500);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, 20'd31);
    send_item(pscr_pkg::CMD_SPIKE, 10'h3FF, 4'h4, $urandom);
    send_item(pscr_pkg::CMD_SPIKE, 10'h2AA, 4'h2, $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd777);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, pscr_pkg::SR_W'(NUM_CELLS));
  endtask

  task automatic test_sampling_rate();
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_SAMPLING_RATE, 20'd0);
    send_item(pscr_pkg::CMD_SPIKE, 10'h000, 4'h0, $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd50);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_SAMPLING_RATE, 20'hFFFFF);
    send_item(pscr_pkg::CMD_SPIKE, 10'h3FF, 4'h1, $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'hFFFF_FFFF);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd3);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_SAMPLING_RATE, 20'd1);
    send_item(pscr_pkg::CMD_SPIKE, 10'h000, 4'h0, $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd1);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_SAMPLING_RATE, pscr_pkg::SR_RESET);
  endtask

  // large rates over a one-sample total, then a long total time
  task automatic test_large_values();
    wait_idle(SETTLE);
    write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, 20'd1);
    write_cfg(pscr_pkg::CFG_SAMPLING_RATE, 20'hFFFFF);
    idling_on = 1'b0;
    for (int k = 0; k < 12; k++)
      send_item(pscr_pkg::CMD_SPIKE, cell_ids[0], pscr_pkg::SLOT_W'($urandom), $urandom);
    send_item(pscr_pkg::CMD_CLOSE, 10'h000, 4'h0, 32'd1);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    for (int k = 0; k < 4; k++)
      send_item(pscr_pkg::CMD_SPIKE, cell_ids[0], pscr_pkg::SLOT_W'($urandom), $urandom);
    for (int k = 0; k < 4; k++)
      send_item(pscr_pkg::CMD_CLOSE, pscr_pkg::ID_W'($urandom), pscr_pkg::SLOT_W'($urandom),
                32'hFFFF_FFFF);
    send_item(pscr_pkg::CMD_REPORT, 10'h000, 4'h0, $urandom);
    wait_idle(SETTLE);
    idling_on = 1'b1;
    write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, pscr_pkg::SR_W'(pscr_pkg::ACT_RESET));
    write_cfg(pscr_pkg::CFG_SAMPLING_RATE, pscr_pkg::SR_RESET);
  endtask

  task automatic test_random_traffic();
    int                         r;
    logic [pscr_pkg::CMD_W-1:0] cmd;
    logic [pscr_pkg::ID_W-1:0]  id;
    logic [pscr_pkg::DUR_W-1:0] dur;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle(SETTLE);
      write_cfg(pscr_pkg::CFG_SAMPLING_RATE, pick_rate());
      write_cfg(pscr_pkg::CFG_ACTIVE_CELLS, pick_active());
      idling_on = (p != 1);
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        r   = $urandom_range(0, 99);
        id  = ($urandom_range(0, 99) < 75) ? cell_ids[$urandom_range(0, NUM_CELLS - 1)]
                                           : pscr_pkg::ID_W'($urandom);
        dur = $urandom;
        if (r < 55) begin
          cmd = pscr_pkg::CMD_SPIKE;
        end else if (r < 75) begin
          cmd = pscr_pkg::CMD_CLOSE;
          if ($urandom_range(0, 99) < 65) dur = $urandom_range(0, 5000);
        end else if (r < 87) begin
          cmd = pscr_pkg::CMD_LOAD;
        end else begin
          cmd = pscr_pkg::CMD_REPORT;
        end
        send_item(cmd, id, pscr_pkg::SLOT_W'($urandom), dur);
        if (cmd == pscr_pkg::CMD_REPORT && $urandom_range(0, 7) == 0) wait_idle(0);
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = pscr_pkg::CMD_SPIKE;
    in_cluster_id = '0;
    in_slot       = '0;
    in_duration   = '0;
    cfg_we        = 1'b0;
    cfg_index     = pscr_pkg::CFG_SAMPLING_RATE;
    cfg_wdata     = '0;
    sr_reg        = pscr_pkg::SR_RESET;
    act_reg       = pscr_pkg::ACT_RESET;
    total_time    = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      spike_cnt[i] = '0;
      cell_ids[i]  = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_load_table();
    test_spike_close_report();
    test_zero_time();
    test_active_cells();
    test_sampling_rate();
    test_large_values();
    test_random_traffic();

    wait_idle(SETTLE);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
